>>> rtl/core/ccr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and widths for the circumcircle center and radius unit.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned OUT_W         = 64;

  // Difference vectors, squared terms, lengths and determinant, numerators.
  localparam int unsigned D_W   = COORD_BITS + 1;
  localparam int unsigned PR_W  = 2 * D_W;
  localparam int unsigned LEN_W = PR_W + 1;
  localparam int unsigned NUM_W = D_W + LEN_W + 1;
  localparam int unsigned DIV_W = LEN_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by_coord;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
  } ccr_in_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic        [OUT_W-1:0] radius_sq;
    logic                    saturated;
  } ccr_out_t;

endpackage
`default_nettype wire

>>> rtl/core/ccr_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_div_pipe
// Two-lane restoring divider, one quotient bit per register stage, shared
// divisor, with sideband carried alongside.
// ----------------------------------------------------------------------------
module ccr_div_pipe #(
  parameter int unsigned DVD_W  = 69,
  parameter int unsigned DIV_W  = 36,
  parameter int unsigned SIDE_W = 35
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [DVD_W-1:0]  num_x_i,
  input  wire logic [DVD_W-1:0]  num_y_i,
  input  wire logic [DIV_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [DVD_W-1:0]       quo_x_o,
  output logic [DVD_W-1:0]       quo_y_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [DIV_W-1:0]  rem_x_q [DVD_W];
  logic [DIV_W-1:0]  rem_y_q [DVD_W];
  logic [DVD_W-1:0]  dq_x_q  [DVD_W];
  logic [DVD_W-1:0]  dq_y_q  [DVD_W];
  logic [DIV_W-1:0]  den_q   [DVD_W];
  logic [SIDE_W-1:0] side_q  [DVD_W];
  logic [DVD_W-1:0]  vld_q;

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [DIV_W-1:0]  rx_in, ry_in, den_in;
    logic [DVD_W-1:0]  dqx_in, dqy_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic [DIV_W:0]    tx, ty;
    logic              gex, gey;

    if (k == 0) begin : g_head
      assign rx_in   = '0;
      assign ry_in   = '0;
      assign dqx_in  = num_x_i;
      assign dqy_in  = num_y_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_tail
      assign rx_in   = rem_x_q[k-1];
      assign ry_in   = rem_y_q[k-1];
      assign dqx_in  = dq_x_q[k-1];
      assign dqy_in  = dq_y_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign tx  = {rx_in, dqx_in[DVD_W-1]};
    assign ty  = {ry_in, dqy_in[DVD_W-1]};
    assign gex = (tx >= {1'b0, den_in});
    assign gey = (ty >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_x_q[k] <= gex ? DIV_W'(tx - {1'b0, den_in}) : tx[DIV_W-1:0];
        rem_y_q[k] <= gey ? DIV_W'(ty - {1'b0, den_in}) : ty[DIV_W-1:0];
        dq_x_q[k]  <= {dqx_in[DVD_W-2:0], gex};
        dq_y_q[k]  <= {dqy_in[DVD_W-2:0], gey};
        den_q[k]   <= den_in;
        side_q[k]  <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[DVD_W-1];
  assign quo_x_o = dq_x_q[DVD_W-1];
  assign quo_y_o = dq_y_q[DVD_W-1];
  assign side_o  = side_q[DVD_W-1];

endmodule
`default_nettype wire

>>> rtl/core/circumcircle_center_radius_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circumcircle_center_radius_unit
// Circumcenter and squared circumradius of an integer triangle, fixed point.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one triangle (three vertices)
// per transaction. Output channel: out_valid_o / out_stall_i carry one result
// per triangle, in order: valid flag, center x/y and squared radius with
// FRAC_BITS fraction bits, and a saturation flag.
// Throughput: one triangle per cycle, sustained while the receiver does not
// stall.
// Pipeline: 7 front stages (input register, differences, squares, lengths,
// products, numerators, magnitudes), the 53 + FRAC_BITS stage divider with
// one quotient bit per stage, and 5 back stages (sign, center add and radius
// partial products, clamp, sum, output register).
// Reset clears every stage valid bit; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module circumcircle_center_radius_unit #(
  parameter int unsigned FRAC_BITS = ccr_pkg::FRAC_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ccr_pkg::ccr_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ccr_pkg::ccr_out_t     out_data_o
);

  localparam int unsigned C      = ccr_pkg::COORD_BITS;
  localparam int unsigned D_W    = ccr_pkg::D_W;
  localparam int unsigned PR_W   = ccr_pkg::PR_W;
  localparam int unsigned LEN_W  = ccr_pkg::LEN_W;
  localparam int unsigned NUM_W  = ccr_pkg::NUM_W;
  localparam int unsigned DIV_W  = ccr_pkg::DIV_W;
  localparam int unsigned OUT_W  = ccr_pkg::OUT_W;
  localparam int unsigned DVD_W  = NUM_W + FRAC_BITS;
  localparam int unsigned QX_W   = (DVD_W > OUT_W) ? DVD_W : OUT_W + 1;
  localparam int unsigned OFF_W  = DVD_W + 1;
  localparam int unsigned CS_W   = DVD_W + 2;
  localparam int unsigned CE_W   = (CS_W > OUT_W) ? CS_W : OUT_W + 1;
  localparam int unsigned SIDE_W = 3 + 2 * C;
  localparam int unsigned HW     = OUT_W / 2;
  localparam int unsigned SQ_W   = 2 * OUT_W;

  localparam logic [OUT_W-1:0] S_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] S_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic en;
  logic [6:0] pre_vld_q;
  logic [4:0] post_vld_q;

  assign en         = !(post_vld_q[4] && out_stall_i);
  assign in_stall_o = !en;

  // S1
  ccr_pkg::ccr_in_t s1_q;
  // S2
  logic signed [D_W-1:0] dx2_q, dy2_q, ex2_q, ey2_q;
  logic signed [C-1:0]   ax2_q, ay2_q;
  // S3
  logic signed [PR_W-1:0] pdxx_q, pdyy_q, pexx_q, peyy_q, pdxey_q, pdyex_q;
  logic signed [D_W-1:0]  dx3_q, dy3_q, ex3_q, ey3_q;
  logic signed [C-1:0]    ax3_q, ay3_q;
  // S4
  logic signed [LEN_W-1:0] bl_q, cl_q, det4_q;
  logic signed [D_W-1:0]   dx4_q, dy4_q, ex4_q, ey4_q;
  logic signed [C-1:0]     ax4_q, ay4_q;
  // S5
  logic signed [NUM_W-2:0] p1_q, p2_q, p3_q, p4_q;
  logic signed [LEN_W-1:0] det5_q;
  logic signed [C-1:0]     ax5_q, ay5_q;
  // S6
  logic signed [NUM_W-1:0] nx_q, ny_q;
  logic signed [LEN_W-1:0] det6_q;
  logic signed [C-1:0]     ax6_q, ay6_q;
  // S7
  logic [NUM_W-1:0]  mx_q, my_q;
  logic [DIV_W-1:0]  den_q;
  logic [SIDE_W-1:0] side7_q;

  logic signed [LEN_W-1:0] absdet;
  assign absdet = det6_q[LEN_W-1] ? -det6_q : det6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q    <= in_data_i;

      dx2_q   <= D_W'(s1_q.bx) - D_W'(s1_q.ax);
      dy2_q   <= D_W'(s1_q.by_coord) - D_W'(s1_q.ay);
      ex2_q   <= D_W'(s1_q.cx) - D_W'(s1_q.ax);
      ey2_q   <= D_W'(s1_q.cy) - D_W'(s1_q.ay);
      ax2_q   <= s1_q.ax;
      ay2_q   <= s1_q.ay;

      pdxx_q  <= PR_W'(dx2_q) * PR_W'(dx2_q);
      pdyy_q  <= PR_W'(dy2_q) * PR_W'(dy2_q);
      pexx_q  <= PR_W'(ex2_q) * PR_W'(ex2_q);
      peyy_q  <= PR_W'(ey2_q) * PR_W'(ey2_q);
      pdxey_q <= PR_W'(dx2_q) * PR_W'(ey2_q);
      pdyex_q <= PR_W'(dy2_q) * PR_W'(ex2_q);
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;
      ex3_q   <= ex2_q;
      ey3_q   <= ey2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;

      bl_q    <= LEN_W'(pdxx_q) + LEN_W'(pdyy_q);
      cl_q    <= LEN_W'(pexx_q) + LEN_W'(peyy_q);
      det4_q  <= LEN_W'(pdxey_q) - LEN_W'(pdyex_q);
      dx4_q   <= dx3_q;
      dy4_q   <= dy3_q;
      ex4_q   <= ex3_q;
      ey4_q   <= ey3_q;
      ax4_q   <= ax3_q;
      ay4_q   <= ay3_q;

      p1_q    <= (NUM_W-1)'(ey4_q) * (NUM_W-1)'(bl_q);
      p2_q    <= (NUM_W-1)'(dy4_q) * (NUM_W-1)'(cl_q);
      p3_q    <= (NUM_W-1)'(dx4_q) * (NUM_W-1)'(cl_q);
      p4_q    <= (NUM_W-1)'(ex4_q) * (NUM_W-1)'(bl_q);
      det5_q  <= det4_q;
      ax5_q   <= ax4_q;
      ay5_q   <= ay4_q;

      nx_q    <= NUM_W'(p1_q) - NUM_W'(p2_q);
      ny_q    <= NUM_W'(p3_q) - NUM_W'(p4_q);
      det6_q  <= det5_q;
      ax6_q   <= ax5_q;
      ay6_q   <= ay5_q;

      mx_q    <= nx_q[NUM_W-1] ? NUM_W'(-nx_q) : NUM_W'(nx_q);
      my_q    <= ny_q[NUM_W-1] ? NUM_W'(-ny_q) : NUM_W'(ny_q);
      den_q   <= {absdet, 1'b0};
      side7_q <= {(det6_q == '0),
                  nx_q[NUM_W-1] ^ det6_q[LEN_W-1],
                  ny_q[NUM_W-1] ^ det6_q[LEN_W-1],
                  ax6_q, ay6_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_vld_q <= '0;
    end else if (en) begin
      pre_vld_q <= {pre_vld_q[5:0], in_valid_i};
    end
  end

  // Divider
  logic              dv_vld;
  logic [DVD_W-1:0]  qx, qy;
  logic [SIDE_W-1:0] dv_side;

  ccr_div_pipe #(
    .DVD_W  (DVD_W),
    .DIV_W  (DIV_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pre_vld_q[6]),
    .num_x_i (DVD_W'(mx_q) << FRAC_BITS),
    .num_y_i (DVD_W'(my_q) << FRAC_BITS),
    .den_i   (den_q),
    .side_i  (side7_q),
    .valid_o (dv_vld),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .side_o  (dv_side)
  );

  // S8: apply sign, split magnitudes
  logic [QX_W-1:0] qxe, qye;
  assign qxe = QX_W'(qx);
  assign qye = QX_W'(qy);

  logic signed [OFF_W-1:0] ox8_q, oy8_q;
  logic [OUT_W-1:0]        mlx8_q, mly8_q;
  logic                    big8_q, z8_q;
  logic signed [C-1:0]     ax8_q, ay8_q;

  // S9: center sums, radius partial products
  logic signed [CS_W-1:0] cxs9_q, cys9_q;
  logic [OUT_W-1:0]       xll_q, xhl_q, xhh_q, yll_q, yhl_q, yhh_q;
  logic                   big9_q, z9_q;

  // S10: clamp, square sums
  logic [OUT_W-1:0] cx10_q, cy10_q;
  logic             csat10_q, big10_q, z10_q;
  logic [SQ_W-1:0]  sx10_q, sy10_q;

  // S11: radius sum
  logic [SQ_W:0]    r11_q;
  logic [OUT_W-1:0] cx11_q, cy11_q;
  logic             csat11_q, big11_q, z11_q;

  // S12: output register
  ccr_pkg::ccr_out_t out_q;

  logic signed [CE_W-1:0] cxe, cye;
  logic                   okx, oky;
  logic [SQ_W-1:0]        rsh;
  logic                   rsat;

  assign cxe = CE_W'(cxs9_q);
  assign cye = CE_W'(cys9_q);
  assign okx = (cxe[CE_W-1:OUT_W-1] == '0) || (cxe[CE_W-1:OUT_W-1] == '1);
  assign oky = (cye[CE_W-1:OUT_W-1] == '0) || (cye[CE_W-1:OUT_W-1] == '1);
  assign rsh  = r11_q[SQ_W-1:0] >> FRAC_BITS;
  assign rsat = big11_q || r11_q[SQ_W] || (rsh[SQ_W-1:OUT_W] != '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox8_q  <= dv_side[SIDE_W-2] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      oy8_q  <= dv_side[SIDE_W-3] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      mlx8_q <= qxe[OUT_W-1:0];
      mly8_q <= qye[OUT_W-1:0];
      big8_q <= (qxe[QX_W-1:OUT_W] != '0) || (qye[QX_W-1:OUT_W] != '0);
      z8_q   <= dv_side[SIDE_W-1];
      ax8_q  <= $signed(dv_side[2*C-1:C]);
      ay8_q  <= $signed(dv_side[C-1:0]);

      cxs9_q <= (CS_W'(ax8_q) <<< FRAC_BITS) + CS_W'(ox8_q);
      cys9_q <= (CS_W'(ay8_q) <<< FRAC_BITS) + CS_W'(oy8_q);
      xll_q  <= OUT_W'(mlx8_q[HW-1:0]) * OUT_W'(mlx8_q[HW-1:0]);
      xhl_q  <= OUT_W'(mlx8_q[OUT_W-1:HW]) * OUT_W'(mlx8_q[HW-1:0]);
      xhh_q  <= OUT_W'(mlx8_q[OUT_W-1:HW]) * OUT_W'(mlx8_q[OUT_W-1:HW]);
      yll_q  <= OUT_W'(mly8_q[HW-1:0]) * OUT_W'(mly8_q[HW-1:0]);
      yhl_q  <= OUT_W'(mly8_q[OUT_W-1:HW]) * OUT_W'(mly8_q[HW-1:0]);
      yhh_q  <= OUT_W'(mly8_q[OUT_W-1:HW]) * OUT_W'(mly8_q[OUT_W-1:HW]);
      big9_q <= big8_q;
      z9_q   <= z8_q;

      cx10_q   <= okx ? cxe[OUT_W-1:0] : (cxe[CE_W-1] ? S_MIN : S_MAX);
      cy10_q   <= oky ? cye[OUT_W-1:0] : (cye[CE_W-1] ? S_MIN : S_MAX);
      csat10_q <= !okx || !oky;
      sx10_q   <= {xhh_q, {OUT_W{1'b0}}} + (SQ_W'(xhl_q) << (HW + 1)) + SQ_W'(xll_q);
      sy10_q   <= {yhh_q, {OUT_W{1'b0}}} + (SQ_W'(yhl_q) << (HW + 1)) + SQ_W'(yll_q);
      big10_q  <= big9_q;
      z10_q    <= z9_q;

      r11_q    <= {1'b0, sx10_q} + {1'b0, sy10_q};
      cx11_q   <= cx10_q;
      cy11_q   <= cy10_q;
      csat11_q <= csat10_q;
      big11_q  <= big10_q;
      z11_q    <= z10_q;

      if (z11_q) begin
        out_q <= '0;
      end else begin
        out_q.valid_res <= 1'b1;
        out_q.center_x  <= cx11_q;
        out_q.center_y  <= cy11_q;
        out_q.radius_sq <= rsat ? '1 : rsh[OUT_W-1:0];
        out_q.saturated <= csat11_q || rsat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_vld_q <= '0;
    end else if (en) begin
      post_vld_q <= {post_vld_q[3:0], dv_vld};
    end
  end

  assign out_valid_o = post_vld_q[4];
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> tb/sv/circumcircle_center_radius_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// circumcircle_center_radius_unit_tb
// Self-checking bench for the circumcircle center and radius unit: directed
// and random triangles, randomly stalled on both sides, checked in order
// against an exact fixed-point predictor.
// ----------------------------------------------------------------------------
module circumcircle_center_radius_unit_tb;

  localparam int unsigned FRAC = ccr_pkg::FRAC_BITS_DEF;
  localparam int unsigned LATENCY = 65 + FRAC;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  ccr_pkg::ccr_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  ccr_pkg::ccr_out_t out_data_o;

  ccr_pkg::ccr_out_t circle_q[$];
  int       error_count = 0;
  int       result_count = 0;
  int       degenerate_count = 0;
  int       clamp_count = 0;
  longint unsigned cycle_count = 0;
  bit       no_idle = 1'b0;

  always #1 clk_i = ~clk_i;

  circumcircle_center_radius_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  function automatic logic signed [63:0] clamp_center(logic signed [127:0] v,
                                                      ref bit sat);
    if (v > 128'sh7FFFFFFFFFFFFFFF) begin
      sat = 1'b1;
      return 64'sh7FFFFFFFFFFFFFFF;
    end
    if (v < -128'sh8000000000000000) begin
      sat = 1'b1;
      return 64'sh8000000000000000;
    end
    return v[63:0];
  endfunction

  function automatic logic signed [127:0] trunc_div(logic signed [127:0] num,
                                                    logic signed [127:0] den);
    logic [127:0] q;
    q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
    return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic ccr_pkg::ccr_out_t circumcircle(ccr_pkg::ccr_in_t t);
    logic signed [127:0] dx, dy, ex, ey, bl, cl, det, ox, oy, mx, my;
    logic [255:0] r;
    ccr_pkg::ccr_out_t o;
    bit sat;
    sat = 1'b0;
    o = '0;
    dx = 128'(t.bx) - 128'(t.ax);
    dy = 128'(t.by_coord) - 128'(t.ay);
    ex = 128'(t.cx) - 128'(t.ax);
    ey = 128'(t.cy) - 128'(t.ay);
    bl = dx * dx + dy * dy;
    cl = ex * ex + ey * ey;
    det = dx * ey - dy * ex;
    if (det == 0) return o;
    ox = trunc_div((ey * bl - dy * cl) <<< FRAC, det * 2);
    oy = trunc_div((dx * cl - ex * bl) <<< FRAC, det * 2);
    o.valid_res = 1'b1;
    o.center_x = clamp_center((128'(t.ax) <<< FRAC) + ox, sat);
    o.center_y = clamp_center((128'(t.ay) <<< FRAC) + oy, sat);
    mx = ox < 0 ? -ox : ox;
    my = oy < 0 ? -oy : oy;
    r = (256'(mx) * 256'(mx) + 256'(my) * 256'(my)) >> FRAC;
    if (r[255:64] != 0) begin
      sat = 1'b1;
      o.radius_sq = '1;
    end else begin
      o.radius_sq = r[63:0];
    end
    o.saturated = sat;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR: result %0d %s got %h want %h", result_count, what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni) out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 33);
    if (out_valid_o && !out_stall_i && rst_ni) begin
      ccr_pkg::ccr_out_t want;
      if (circle_q.size() == 0) begin
        $display("ERROR: unexpected result %0d", result_count);
        error_count++;
      end else begin
        want = circle_q.pop_front();
        if (out_data_o.valid_res !== want.valid_res)
          report_mismatch("valid_res", 64'(out_data_o.valid_res), 64'(want.valid_res));
        if (out_data_o.center_x !== want.center_x)
          report_mismatch("center_x", out_data_o.center_x, want.center_x);
        if (out_data_o.center_y !== want.center_y)
          report_mismatch("center_y", out_data_o.center_y, want.center_y);
        if (out_data_o.radius_sq !== want.radius_sq)
          report_mismatch("radius_sq", out_data_o.radius_sq, want.radius_sq);
        if (out_data_o.saturated !== want.saturated)
          report_mismatch("saturated", 64'(out_data_o.saturated), 64'(want.saturated));
        if (!want.valid_res) degenerate_count++;
        if (want.saturated) clamp_count++;
      end
      result_count++;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circumcircle_center_radius_unit verification failed");
      $finish;
    end
  end

  task automatic send_triangle(ccr_pkg::ccr_in_t t);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    circle_q = {circle_q, circumcircle(t)};
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(40)) - 20);
      2: return $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(3))
                                  : 16'h8000 + 16'($urandom_range(3));
      default: return 16'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic ccr_pkg::ccr_in_t make_tri(int ax, int ay, int bx, int by, int cx,
                                                int cy);
    ccr_pkg::ccr_in_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx);
    t.by_coord = 16'(by); t.cx = 16'(cx); t.cy = 16'(cy);
    return t;
  endfunction

  task automatic test_directed();
    send_triangle(make_tri(0, 0, 1, 0, 0, 1));
    send_triangle(make_tri(0, 0, 4, 0, 0, 3));
    send_triangle(make_tri(5, 5, 5, 5, 5, 5));
    send_triangle(make_tri(0, 0, 1, 1, 2, 2));
    send_triangle(make_tri(3, -7, 3, -7, 9, 2));
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 0, 0));
    send_triangle(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    send_triangle(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
    send_triangle(make_tri(-32768, 0, 32767, 1, 0, 0));
    send_triangle(make_tri(-32768, -32768, 32767, -32767, -32767, -32766));
    send_triangle(make_tri(0, 0, 32767, 0, 32766, 1));
    send_triangle(make_tri(32767, -32768, -32768, 32767, -32767, 32767));
    send_triangle(make_tri(-1, -1, 1, -1, 0, 1));
    send_triangle(make_tri(0, 0, 0, 1, 1, 0));
    send_triangle(make_tri(-32768, 32767, -32767, -32768, 32767, -32767));
    send_triangle(make_tri(1, 2, 3, 5, 7, 11));
    idle_input();
  endtask

  task automatic test_random(int count);
    ccr_pkg::ccr_in_t t;
    for (int i = 0; i < count; i++) begin
      t = make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
      if ($urandom_range(9) == 0) begin
        t.cx = 16'(2 * int'(t.bx) - int'(t.ax));
        t.cy = 16'(2 * int'(t.by_coord) - int'(t.ay));
      end
      send_triangle(t);
    end
    idle_input();
  endtask

  task automatic drain_results();
    while (circle_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    drain_results();
    test_random(600);
    no_idle = 1'b1;
    test_random(400);
    no_idle = 1'b0;
    test_random(530);
    drain_results();
    $display("Checked %0d triangles: %0d degenerate, %0d with clamped results.",
             result_count, degenerate_count, clamp_count);
    if (error_count == 0) begin
      $display("circumcircle_center_radius_unit verification clean");
    end else begin
      $display("circumcircle_center_radius_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> circumcircle_center_radius_unit.f
rtl/core/ccr_pkg.sv
rtl/core/ccr_div_pipe.sv
rtl/core/circumcircle_center_radius_unit.sv
tb/sv/circumcircle_center_radius_unit_tb.sv
